@@ rtl/pbwfp_pkg.sv @@
// ============================================================================
// Protobuf wire field parser package
// Shared types and constants for the wire-format field parser.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pbwfp_pkg;

    localparam int MAX_BUFFER_BYTES_DEF = 65536;
    localparam int VARINT_MAX_BYTES     = 10;
    localparam int VARINT_BITS          = 7;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    localparam logic [15:0] FIXED64_BYTES = 16'd8;
    localparam logic [15:0] FIXED32_BYTES = 16'd4;

    typedef enum logic [2:0] {
        PH_KEY,
        PH_VALUE,
        PH_LEN,
        PH_SKIP,
        PH_DRAIN
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_TAG  = 3'd1,
        ST_BAD_TYPE  = 3'd2,
        ST_LONG      = 3'd3,
        ST_TRUNC     = 3'd4,
        ST_TOO_BIG   = 3'd5
    } status_t;

    // Packed with the last field in the lowest bits.
    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] payload_length;
        logic [15:0] payload_offset;
        logic [63:0] varint_value;
        logic [2:0]  wire_type;
        logic [31:0] tag;
        status_t     status;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/protobuf_wire_field_parser.sv @@
// ============================================================================
// Protobuf wire field parser
// Parses wire-format fields from a byte stream and reports one item per field.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

// One byte is taken per cycle while s_tready is high, and every byte is
// handled in the cycle that accepts it, so the sustained rate is one item per
// clock. The result of the byte that completes a field or raises an error is
// registered toward the master side. Results sit in an output register backed
// by a one-entry skid register, and s_tready drops only while both hold
// results. After an error, bytes are consumed without results until the byte
// flagged by s_tlast, after which the parser starts over at offset zero.
module protobuf_wire_field_parser #(
    parameter int MAX_BUFFER_BYTES = pbwfp_pkg::MAX_BUFFER_BYTES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic         s_tlast,   // last
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata    // status, tag, wire_type, varint_value,
                                         // payload_offset, payload_length, zero pad
);

    localparam int MAXW = $clog2(MAX_BUFFER_BYTES + 1);
    localparam int SUMW = ((MAXW > 17) ? MAXW : 17) + 1;

    pbwfp_pkg::phase_t  phase_reg, phase_next;
    logic [63:0]        acc_reg, acc_next;
    logic [3:0]         sc_reg, sc_next;
    logic [31:0]        tag_reg, tag_next;
    logic [2:0]         wt_reg, wt_next;
    logic [15:0]        skip_reg, skip_next;
    logic [15:0]        pos_reg, pos_next;
    logic [15:0]        pstart_reg, pstart_next;

    pbwfp_pkg::result_t out_reg, skid_reg, res_c;
    logic               out_valid_reg, skid_valid_reg, res_valid_c;

    logic               accept, push, pop;
    logic [63:0]        shifted, acc_new;
    logic [3:0]         sc_inc;
    logic               vdone, vlong;
    logic [31:0]        key_tag;
    logic [2:0]         key_wt;
    logic [15:0]        pos_inc, skip_dec;
    logic [SUMW-1:0]    end_sum;
    logic               too_big;

    assign accept = s_tvalid && s_tready;
    assign push   = accept && res_valid_c;
    assign pop    = out_valid_reg && m_tready;

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb
    begin
        shifted = '0;
        for (int i = 0; i < pbwfp_pkg::VARINT_MAX_BYTES; i++)
        begin
            if (sc_reg == 4'(i))
            begin
                shifted = 64'(s_tdata[6:0]) << (pbwfp_pkg::VARINT_BITS * i);
            end
        end
    end

    assign acc_new  = acc_reg | shifted;
    assign sc_inc   = sc_reg + 4'd1;
    assign vdone    = !s_tdata[7];
    assign vlong    = s_tdata[7] && (sc_inc >= 4'(pbwfp_pkg::VARINT_MAX_BYTES));
    assign key_tag  = acc_new[34:3];
    assign key_wt   = acc_new[2:0];
    assign pos_inc  = pos_reg + 16'd1;
    assign skip_dec = skip_reg - 16'd1;
    assign end_sum  = SUMW'(pos_reg) + SUMW'(1) + SUMW'(acc_new[15:0]);
    assign too_big  = (acc_new[63:16] != '0) || (end_sum > SUMW'(MAX_BUFFER_BYTES));

    // Result of the current byte.
    always_comb
    begin
        res_valid_c = 1'b0;
        res_c       = '0;
        res_c.status = pbwfp_pkg::ST_OK;
        unique case (phase_reg)
            pbwfp_pkg::PH_KEY:
            begin
                if (vlong)
                begin
                    res_valid_c  = 1'b1;
                    res_c.status = pbwfp_pkg::ST_LONG;
                end
                else if (!vdone)
                begin
                    if (s_tlast)
                    begin
                        res_valid_c  = 1'b1;
                        res_c.status = pbwfp_pkg::ST_TRUNC;
                    end
                end
                else if (key_tag == '0)
                begin
                    res_valid_c     = 1'b1;
                    res_c.status    = pbwfp_pkg::ST_ZERO_TAG;
                    res_c.wire_type = key_wt;
                end
                else
                begin
                    case (key_wt) inside
                        pbwfp_pkg::WT_VARINT, pbwfp_pkg::WT_FIXED64,
                        pbwfp_pkg::WT_LEN, pbwfp_pkg::WT_FIXED32:
                        begin
                            if (s_tlast)
                            begin
                                res_valid_c  = 1'b1;
                                res_c.status = pbwfp_pkg::ST_TRUNC;
                            end
                        end
                        default:
                        begin
                            res_valid_c  = 1'b1;
                            res_c.status = pbwfp_pkg::ST_BAD_TYPE;
                        end
                    endcase
                    res_c.tag       = key_tag;
                    res_c.wire_type = key_wt;
                end
            end
            pbwfp_pkg::PH_VALUE, pbwfp_pkg::PH_LEN:
            begin
                res_c.tag       = tag_reg;
                res_c.wire_type = wt_reg;
                if (vlong)
                begin
                    res_valid_c  = 1'b1;
                    res_c.status = pbwfp_pkg::ST_LONG;
                end
                else if (!vdone)
                begin
                    if (s_tlast)
                    begin
                        res_valid_c  = 1'b1;
                        res_c.status = pbwfp_pkg::ST_TRUNC;
                    end
                end
                else if (phase_reg == pbwfp_pkg::PH_VALUE)
                begin
                    res_valid_c        = 1'b1;
                    res_c.varint_value = acc_new;
                end
                else if (too_big)
                begin
                    res_valid_c  = 1'b1;
                    res_c.status = pbwfp_pkg::ST_TOO_BIG;
                end
                else if (acc_new[15:0] == '0)
                begin
                    res_valid_c          = 1'b1;
                    res_c.payload_offset = pos_inc;
                end
                else if (s_tlast)
                begin
                    res_valid_c  = 1'b1;
                    res_c.status = pbwfp_pkg::ST_TOO_BIG;
                end
            end
            pbwfp_pkg::PH_SKIP:
            begin
                res_c.tag       = tag_reg;
                res_c.wire_type = wt_reg;
                if (skip_dec == '0)
                begin
                    res_valid_c          = 1'b1;
                    res_c.payload_offset = pstart_reg;
                    res_c.payload_length = acc_reg[15:0];
                end
                else if (s_tlast)
                begin
                    res_valid_c  = 1'b1;
                    res_c.status = (wt_reg == pbwfp_pkg::WT_LEN) ?
                                   pbwfp_pkg::ST_TOO_BIG : pbwfp_pkg::ST_TRUNC;
                end
            end
            default:
            begin
                res_valid_c = 1'b0;
            end
        endcase
    end

    // Parser state update.
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        sc_next     = sc_reg;
        tag_next    = tag_reg;
        wt_next     = wt_reg;
        skip_next   = skip_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        if (accept)
        begin
            pos_next = pos_inc;
            unique case (phase_reg)
                pbwfp_pkg::PH_KEY:
                begin
                    acc_next = acc_new;
                    sc_next  = sc_inc;
                    if (vdone)
                    begin
                        tag_next = key_tag;
                        wt_next  = key_wt;
                        acc_next = '0;
                        sc_next  = '0;
                        case (key_wt)
                            pbwfp_pkg::WT_VARINT:
                            begin
                                phase_next = pbwfp_pkg::PH_VALUE;
                            end
                            pbwfp_pkg::WT_LEN:
                            begin
                                phase_next = pbwfp_pkg::PH_LEN;
                            end
                            pbwfp_pkg::WT_FIXED64:
                            begin
                                phase_next  = pbwfp_pkg::PH_SKIP;
                                pstart_next = pos_inc;
                                skip_next   = pbwfp_pkg::FIXED64_BYTES;
                                acc_next    = 64'(pbwfp_pkg::FIXED64_BYTES);
                            end
                            pbwfp_pkg::WT_FIXED32:
                            begin
                                phase_next  = pbwfp_pkg::PH_SKIP;
                                pstart_next = pos_inc;
                                skip_next   = pbwfp_pkg::FIXED32_BYTES;
                                acc_next    = 64'(pbwfp_pkg::FIXED32_BYTES);
                            end
                            default:
                            begin
                                phase_next = pbwfp_pkg::PH_DRAIN;
                            end
                        endcase
                    end
                end
                pbwfp_pkg::PH_VALUE:
                begin
                    acc_next = acc_new;
                    sc_next  = sc_inc;
                end
                pbwfp_pkg::PH_LEN:
                begin
                    acc_next = acc_new;
                    sc_next  = sc_inc;
                    if (vdone)
                    begin
                        sc_next     = '0;
                        phase_next  = pbwfp_pkg::PH_SKIP;
                        pstart_next = pos_inc;
                        skip_next   = acc_new[15:0];
                    end
                end
                pbwfp_pkg::PH_SKIP:
                begin
                    skip_next = skip_dec;
                end
                default:
                begin
                    phase_next = pbwfp_pkg::PH_DRAIN;
                end
            endcase
            if (res_valid_c)
            begin
                if (res_c.status == pbwfp_pkg::ST_OK)
                begin
                    phase_next = pbwfp_pkg::PH_KEY;
                    acc_next   = '0;
                    sc_next    = '0;
                end
                else
                begin
                    phase_next = pbwfp_pkg::PH_DRAIN;
                end
            end
            if (s_tlast)
            begin
                phase_next  = pbwfp_pkg::PH_KEY;
                acc_next    = '0;
                sc_next     = '0;
                tag_next    = '0;
                wt_next     = '0;
                skip_next   = '0;
                pos_next    = '0;
                pstart_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= pbwfp_pkg::PH_KEY;
            acc_reg        <= '0;
            sc_reg         <= '0;
            tag_reg        <= '0;
            wt_reg         <= '0;
            skip_reg       <= '0;
            pos_reg        <= '0;
            pstart_reg     <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            sc_reg     <= sc_next;
            tag_reg    <= tag_next;
            wt_reg     <= wt_next;
            skip_reg   <= skip_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (out_valid_reg && !pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= res_c;
            end
            else
            begin
                out_reg <= res_c;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds an item while the output register is empty.");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=>
        (phase_reg == pbwfp_pkg::PH_KEY && pos_reg == '0 && sc_reg == '0))
        else $error("Parser did not restart after the last byte.");

    a_varint_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != pbwfp_pkg::PH_DRAIN) |->
        (sc_reg < 4'(pbwfp_pkg::VARINT_MAX_BYTES)))
        else $error("Varint byte count ran past its limit.");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pbwfp_pkg::PH_SKIP) |-> (skip_reg != '0))
        else $error("Payload skip entered with nothing left to skip.");

    a_ok_has_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == pbwfp_pkg::ST_OK) |-> (out_reg.tag != '0))
        else $error("Completed field reported with a zero tag.");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

// ============================================================================
// Protobuf wire field parser testbench
// Feeds directed and random wire-format buffers byte by byte through the
// parser. Each accepted byte is run through a local copy of the parsing rules,
// and every field result is checked in order against those predictions.
// ============================================================================
module tb_top;
    import pbwfp_pkg::*;

    localparam int QUIET_TAIL = 150;
    localparam int RANDOM_BYTES = 1620;
    localparam int VT_MORE = 0;
    localparam int VT_DONE = 1;
    localparam int VT_LONG = 2;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain_first;
    } wire_byte_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;     // data_byte
    logic         s_tlast = 1'b0;     // last
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;            // status, tag, wire_type, varint_value,
                                      // payload_offset, payload_length, zero pad

    phase_t      cur_phase;
    logic [63:0] vacc;
    logic [3:0]  vcount;
    logic [31:0] fld_tag;
    logic [2:0]  fld_wt;
    logic [15:0] skip_left;
    logic [15:0] buf_pos;
    logic [15:0] pay_start;

    logic [7:0] frame_buf[$];
    wire_byte_t pending_bytes[$];
    result_t    expected_fields[$];

    bit byte_taken = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int send_pct = 15;
    int recv_pct = 15;
    int mismatch_count = 0;
    int frames_built = 0;
    int bytes_queued = 0;
    int results_seen = 0;
    int status_hits[6];

    protobuf_wire_field_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic clear_parser();
        cur_phase = PH_KEY;
        vacc = 64'd0;
        vcount = 4'd0;
        fld_tag = 32'd0;
        fld_wt = 3'd0;
        skip_left = 16'd0;
        buf_pos = 16'd0;
        pay_start = 16'd0;
    endtask

    function automatic int take_varint_byte(logic [7:0] b);
        int sh;
        sh = 7 * int'(vcount);
        if (sh < 64)
            vacc = vacc | ({57'd0, b[6:0]} << sh);
        vcount = vcount + 4'd1;
        if (!b[7])
            return VT_DONE;
        if (vcount >= 4'd10)
            return VT_LONG;
        return VT_MORE;
    endfunction

    function automatic result_t make_result(status_t st, logic [31:0] tg, logic [2:0] wt,
                                            logic [63:0] val, logic [15:0] off,
                                            logic [15:0] len);
        result_t r;
        r = '0;
        r.status = st;
        r.tag = tg;
        r.wire_type = wt;
        r.varint_value = val;
        r.payload_offset = off;
        r.payload_length = len;
        return r;
    endfunction

    function automatic result_t error_result(status_t st, logic [31:0] tg, logic [2:0] wt);
        cur_phase = PH_DRAIN;
        return make_result(st, tg, wt, 64'd0, 16'd0, 16'd0);
    endfunction

    task automatic start_skip(logic [15:0] count);
        pay_start = buf_pos + 16'd1;
        skip_left = count;
        vacc = {48'd0, count};
        cur_phase = PH_SKIP;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last,
                              output bit got, output result_t r);
        int code;
        logic [63:0] len;
        got = 1'b0;
        r = '0;
        case (cur_phase)
            PH_KEY:
            begin
                code = take_varint_byte(b);
                if (code == VT_LONG)
                begin
                    got = 1'b1;
                    r = error_result(ST_LONG, 32'd0, 3'd0);
                end
                else if (code == VT_MORE)
                begin
                    if (last)
                    begin
                        got = 1'b1;
                        r = error_result(ST_TRUNC, 32'd0, 3'd0);
                    end
                end
                else
                begin
                    fld_tag = vacc[34:3];
                    fld_wt = vacc[2:0];
                    vacc = 64'd0;
                    vcount = 4'd0;
                    if (fld_tag == 32'd0)
                    begin
                        got = 1'b1;
                        r = error_result(ST_ZERO_TAG, 32'd0, fld_wt);
                    end
                    else
                    begin
                        case (fld_wt)
                            WT_VARINT:  cur_phase = PH_VALUE;
                            WT_LEN:     cur_phase = PH_LEN;
                            WT_FIXED64: start_skip(FIXED64_BYTES);
                            WT_FIXED32: start_skip(FIXED32_BYTES);
                            default:
                            begin
                                got = 1'b1;
                                r = error_result(ST_BAD_TYPE, fld_tag, fld_wt);
                            end
                        endcase
                        if (!got && last)
                        begin
                            got = 1'b1;
                            r = error_result(ST_TRUNC, fld_tag, fld_wt);
                        end
                    end
                end
            end
            PH_VALUE:
            begin
                code = take_varint_byte(b);
                if (code == VT_LONG)
                begin
                    got = 1'b1;
                    r = error_result(ST_LONG, fld_tag, fld_wt);
                end
                else if (code == VT_MORE)
                begin
                    if (last)
                    begin
                        got = 1'b1;
                        r = error_result(ST_TRUNC, fld_tag, fld_wt);
                    end
                end
                else
                begin
                    got = 1'b1;
                    r = make_result(ST_OK, fld_tag, fld_wt, vacc, 16'd0, 16'd0);
                    vacc = 64'd0;
                    vcount = 4'd0;
                    cur_phase = PH_KEY;
                end
            end
            PH_LEN:
            begin
                code = take_varint_byte(b);
                if (code == VT_LONG)
                begin
                    got = 1'b1;
                    r = error_result(ST_LONG, fld_tag, fld_wt);
                end
                else if (code == VT_MORE)
                begin
                    if (last)
                    begin
                        got = 1'b1;
                        r = error_result(ST_TRUNC, fld_tag, fld_wt);
                    end
                end
                else
                begin
                    len = vacc;
                    vcount = 4'd0;
                    if (len > 64'hFFFF ||
                        {48'd0, buf_pos} + 64'd1 + len > MAX_BUFFER_BYTES_DEF)
                    begin
                        got = 1'b1;
                        r = error_result(ST_TOO_BIG, fld_tag, fld_wt);
                    end
                    else if (len == 64'd0)
                    begin
                        got = 1'b1;
                        r = make_result(ST_OK, fld_tag, fld_wt, 64'd0, buf_pos + 16'd1, 16'd0);
                        vacc = 64'd0;
                        cur_phase = PH_KEY;
                    end
                    else
                    begin
                        start_skip(len[15:0]);
                        if (last)
                        begin
                            got = 1'b1;
                            r = error_result(ST_TOO_BIG, fld_tag, fld_wt);
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0)
                begin
                    got = 1'b1;
                    r = make_result(ST_OK, fld_tag, fld_wt, 64'd0, pay_start, vacc[15:0]);
                    vacc = 64'd0;
                    cur_phase = PH_KEY;
                end
                else if (last)
                begin
                    got = 1'b1;
                    r = error_result((fld_wt == WT_LEN) ? ST_TOO_BIG : ST_TRUNC,
                                     fld_tag, fld_wt);
                end
            end
            default:
            begin
            end
        endcase
        buf_pos = buf_pos + 16'd1;
        if (last)
            clear_parser();
    endtask

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    function automatic bit is_known_type(logic [2:0] wt);
        return wt == WT_VARINT || wt == WT_FIXED64 || wt == WT_LEN || wt == WT_FIXED32;
    endfunction

    task automatic append_byte(logic [7:0] b);
        frame_buf.insert(frame_buf.size(), b);
    endtask

    task automatic put_varint(logic [63:0] v, int pad);
        int count;
        int total;
        logic [63:0] rest;
        count = 1;
        rest = v >> 7;
        while (rest != 64'd0)
        begin
            count++;
            rest = rest >> 7;
        end
        total = (count + pad > VARINT_MAX_BYTES) ? VARINT_MAX_BYTES : count + pad;
        rest = v;
        for (int i = 0; i < total; i++)
        begin
            append_byte({(i < total - 1) ? 1'b1 : 1'b0, rest[6:0]});
            rest = rest >> 7;
        end
    endtask

    task automatic put_key(logic [60:0] tag, logic [2:0] wt, int pad);
        put_varint({tag, wt}, pad);
    endtask

    task automatic put_payload(int n);
        repeat (n) append_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic push_frame(int keep, bit drain);
        wire_byte_t wb;
        for (int i = 0; i < keep; i++)
        begin
            wb.data = frame_buf[i];
            wb.last = (i == keep - 1);
            wb.drain_first = drain && (i == 0);
            pending_bytes.insert(pending_bytes.size(), wb);
        end
        bytes_queued += keep;
        frames_built++;
        frame_buf.delete();
    endtask

    function automatic logic [60:0] rand_tag();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        case ($urandom_range(0, 3))
            0, 1: return 61'($urandom_range(1, 15));
            2: return 61'($urandom_range(16, 32'h1000_0000));
            default: return wide[60:0];
        endcase
    endfunction

    function automatic int pad_amount();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    task automatic put_good_field();
        logic [2:0] wt;
        logic [63:0] val;
        int n;
        case ($urandom_range(0, 3))
            0: wt = WT_VARINT;
            1: wt = WT_FIXED64;
            2: wt = WT_LEN;
            default: wt = WT_FIXED32;
        endcase
        put_key(rand_tag(), wt, pad_amount());
        case (wt)
            WT_VARINT:
            begin
                val = {$urandom(), $urandom()};
                put_varint(val >> $urandom_range(0, 64), pad_amount());
            end
            WT_LEN:
            begin
                n = ($urandom_range(0, 99) < 3) ? $urandom_range(13, 300) : $urandom_range(0, 12);
                put_varint(64'(n), pad_amount());
                put_payload(n);
            end
            WT_FIXED64: put_payload(8);
            default: put_payload(4);
        endcase
    endtask

    task automatic put_broken_field();
        logic [2:0] wt;
        logic [63:0] val;
        val = {$urandom(), $urandom()};
        case ($urandom_range(0, 4))
            0:
            begin
                do wt = 3'($urandom_range(0, 7)); while (is_known_type(wt));
                put_key(rand_tag(), wt, 0);
            end
            1: put_key(61'd0, 3'($urandom_range(0, 7)), pad_amount());
            2:
            begin
                case ($urandom_range(0, 2))
                    0: ;
                    1: put_key(rand_tag(), WT_VARINT, 0);
                    default: put_key(rand_tag(), WT_LEN, 0);
                endcase
                repeat (10) append_byte({1'b1, 7'($urandom_range(0, 127))});
            end
            3:
            begin
                put_key(rand_tag(), WT_LEN, 0);
                case ($urandom_range(0, 2))
                    0: put_varint(64'hFFFF, 0);
                    1: put_varint(64'h1_0000 + 64'($urandom_range(0, 70000)), 0);
                    default: put_varint(val | 64'h8000_0000_0000_0000, 0);
                endcase
            end
            default: put_payload($urandom_range(1, 8));
        endcase
    endtask

    task automatic build_random_frame();
        int nfields;
        int bad_at;
        int keep;
        bit broken;
        nfields = $urandom_range(1, 6);
        broken = $urandom_range(0, 99) < 15;
        bad_at = broken ? $urandom_range(0, nfields - 1) : -1;
        for (int i = 0; i < nfields; i++)
        begin
            if (i == bad_at)
                put_broken_field();
            else
                put_good_field();
        end
        if (broken && $urandom_range(0, 2) == 0)
            put_payload($urandom_range(1, 6));
        keep = frame_buf.size();
        if ((broken && $urandom_range(0, 2) == 0) || $urandom_range(0, 19) == 0)
            keep = $urandom_range(1, frame_buf.size());
        push_frame(keep, frames_built % 40 == 0);
    endtask

    initial
    begin : stimulus
        int random_start;
        clear_parser();

        // Well-formed fields of the short kinds, ending between fields.
        put_key(61'd1, WT_VARINT, 0);
        put_varint(64'd0, 0);
        put_key(61'd1, WT_FIXED32, 0);
        put_payload(4);
        put_key(61'd2, WT_LEN, 0);
        put_varint(64'd0, 0);
        push_frame(frame_buf.size(), 1'b0);

        // Largest value, largest key, padded varints.
        put_key(61'd1, WT_VARINT, 0);
        put_varint('1, 0);
        put_key('1, WT_FIXED64, 0);
        put_payload(8);
        put_key(61'd3, WT_LEN, 0);
        put_varint(64'd3, 0);
        put_payload(3);
        put_key(61'd4, WT_VARINT, 9);
        put_varint(64'd5, 9);
        push_frame(frame_buf.size(), 1'b0);

        // Zero tag, then bytes that are ignored until the end of the buffer.
        put_key(61'd0, WT_LEN, 0);
        put_payload(3);
        push_frame(frame_buf.size(), 1'b0);

        for (int wt = 0; wt < 8; wt++)
        begin
            if (!is_known_type(3'(wt)))
            begin
                put_key(61'd1, 3'(wt), 0);
                push_frame(frame_buf.size(), 1'b0);
            end
        end

        // Overlong key and overlong value.
        repeat (10) append_byte(8'h80);
        push_frame(frame_buf.size(), 1'b0);
        put_key(61'd1, WT_VARINT, 0);
        repeat (10) append_byte(8'hFF);
        push_frame(frame_buf.size(), 1'b0);

        // Buffers cut inside a key, a value, a fixed payload and a length field.
        append_byte(8'h88);
        push_frame(1, 1'b0);
        put_key(61'd1, WT_VARINT, 0);
        push_frame(1, 1'b0);
        put_key(61'd1, WT_VARINT, 0);
        put_varint(64'd300, 0);
        push_frame(2, 1'b0);
        put_key(61'd1, WT_FIXED64, 0);
        put_payload(8);
        push_frame(3, 1'b0);
        put_key(61'd2, WT_LEN, 0);
        put_varint(64'd5, 0);
        put_payload(5);
        push_frame(2, 1'b0);
        put_key(61'd2, WT_LEN, 0);
        put_varint(64'd5, 0);
        put_payload(5);
        push_frame(4, 1'b0);

        // Declared lengths beyond the buffer limit.
        put_key(61'd2, WT_LEN, 0);
        put_varint(64'hFFFF, 0);
        push_frame(frame_buf.size(), 1'b0);
        put_key(61'd2, WT_LEN, 0);
        put_varint(64'h1_0000, 0);
        push_frame(frame_buf.size(), 1'b0);
        put_key(61'd2, WT_LEN, 0);
        put_varint('1, 0);
        push_frame(frame_buf.size(), 1'b0);

        random_start = bytes_queued;
        while (bytes_queued - random_start < RANDOM_BYTES)
            build_random_frame();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_fields.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d buffers, %0d bytes and %0d results; %0d fields parsed cleanly.",
                 frames_built, bytes_queued, results_seen, status_hits[ST_OK]);
        $display("Errors seen: zero tag %0d, bad type %0d, long varint %0d, cut %0d, too big %0d.",
                 status_hits[ST_ZERO_TAG], status_hits[ST_BAD_TYPE], status_hits[ST_LONG],
                 status_hits[ST_TRUNC], status_hits[ST_TOO_BIG]);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
        begin
            send_pct = pick_pct();
            recv_pct = pick_pct();
        end
    end

    always @(negedge clk)
    begin : sender
        wire_byte_t nb;
        if (rst_n && (!s_tvalid || byte_taken))
        begin
            byte_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_bytes.size() == 0 ||
                     (pending_bytes[0].drain_first && expected_fields.size() != 0))
            begin
                s_tvalid <= 1'b0;
            end
            else if (pending_bytes.size() > QUIET_TAIL && $urandom_range(0, 99) < send_pct)
            begin
                send_gap = $urandom_range(0, 7);
                s_tvalid <= 1'b0;
            end
            else
            begin
                nb = pending_bytes.pop_front();
                s_tdata <= nb.data;
                s_tlast <= nb.last;
                s_tvalid <= 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (pending_bytes.size() > QUIET_TAIL && $urandom_range(0, 99) < recv_pct)
        begin
            stall_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        bit produced;
        result_t predicted;
        result_t seen;
        result_t want;
        if (s_tvalid && s_tready)
        begin
            byte_taken = 1'b1;
            parse_byte(s_tdata, s_tlast, produced, predicted);
            if (produced)
                expected_fields.insert(expected_fields.size(), predicted);
        end
        if (m_tvalid && m_tready)
        begin
            seen = result_t'(m_tdata);
            results_seen++;
            if (expected_fields.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result, status %0d tag %0h",
                                          seen.status, seen.tag));
            end
            else
            begin
                want = expected_fields.pop_front();
                status_hits[int'(want.status)]++;
                check_field("status", seen.status, want.status);
                check_field("tag", seen.tag, want.tag);
                check_field("wire_type", seen.wire_type, want.wire_type);
                check_field("varint_value", seen.varint_value, want.varint_value);
                check_field("payload_offset", seen.payload_offset, want.payload_offset);
                check_field("payload_length", seen.payload_length, want.payload_length);
            end
        end
    end

endmodule

@@ sim.f @@
rtl/pbwfp_pkg.sv
rtl/protobuf_wire_field_parser.sv
test/tb_top.sv
